FILE: rtl/tcce_pkg.sv
// Shared constants and types for the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 11;
  localparam int OFFSET_W = 12;

  localparam logic [COL_W-1:0]    COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]    ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]    COLUMN_MAX = '1;
  localparam logic [ROW_W-1:0]    ROW_LIMIT  = ROW_W'(ROWS);
  localparam logic [OFFSET_W-1:0] COLS_MUL   = OFFSET_W'(COLUMNS);
  localparam logic [COL_W:0]      TAB_STEP   = (COL_W+1)'(8);

  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;

  typedef struct packed {
    logic                screen_clear;
    logic                write_valid;
    logic [CELL_W-1:0]   write_cell;
    logic [CHAR_W-1:0]   write_char;
    logic [OFFSET_W-1:0] cursor_pos;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } cursor_t;

endpackage

FILE: rtl/text_console_cursor_engine.sv
// Text console cursor engine: one character word in, one result word out, every cycle
// while results are taken. Each accepted character word gives exactly one result word.
// A word is taken into an input register, stepped through the cursor logic and captured
// in the result register once that register can load, and one word per cycle is
// sustained while results are taken. The cursor (column, row) advances when a word
// moves from the input register to the result register. Line wrap, screen wrap and the
// screen_clear flag apply at the start of the word after the overflow.
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  logic [CHAR_W-1:0]   char_code,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                screen_clear,
  output logic                write_valid,
  output logic [CELL_W-1:0]   write_cell,
  output logic [CHAR_W-1:0]   write_char,
  output logic [OFFSET_W-1:0] cursor_pos
);

  logic              in_full;
  logic [CHAR_W-1:0] in_char;
  cursor_t           cursor;
  cursor_t           cursor_next;
  result_t           step_result;
  result_t           out_data;
  logic              can_load;
  logic              advance;

  assign advance    = in_full && can_load;
  assign char_ready = !in_full || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (advance) begin
      cursor <= cursor_next;
    end
  end

  tcce_step u_step (
    .cursor      (cursor),
    .char_code   (in_char),
    .cursor_next (cursor_next),
    .result      (step_result)
  );

  tcce_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_full),
    .load_data (step_result),
    .can_load  (can_load),
    .valid     (result_valid),
    .ready     (result_ready),
    .data      (out_data)
  );

  assign screen_clear = out_data.screen_clear;
  assign write_valid  = out_data.write_valid;
  assign write_cell   = out_data.write_cell;
  assign write_char   = out_data.write_char;
  assign cursor_pos   = out_data.cursor_pos;

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cursor))
    else $error("cursor moved without a word advancing");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    cursor.row <= ROW_LIMIT)
    else $error("row beyond screen limit");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !write_valid |-> write_cell == '0 && write_char == '0)
    else $error("write fields nonzero without a write");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |-> !char_ready)
    else $error("input taken while input register is stalled");

endmodule

FILE: rtl/tcce_step.sv
// Combinational cursor update and cell write decode for one character word.
module tcce_step import tcce_pkg::*; (
  input  cursor_t           cursor,
  input  logic [CHAR_W-1:0] char_code,
  output cursor_t           cursor_next,
  output result_t           result
);

  logic [COL_W-1:0]    col_pre;
  logic [ROW_W-1:0]    row_pre;
  logic                clr;
  logic [OFFSET_W-1:0] cell_full;
  logic [COL_W:0]      tab_sum;
  logic [COL_W-1:0]    col_n;
  logic [ROW_W-1:0]    row_n;

  always_comb begin
    col_pre = cursor.column;
    row_pre = cursor.row;
    clr     = 1'b0;
    if (cursor.column > COL_LAST) begin
      col_pre = '0;
      row_pre = cursor.row + ROW_W'(1);
    end
    if (row_pre > ROW_LAST) begin
      row_pre = '0;
      clr     = 1'b1;
    end
  end

  assign cell_full = OFFSET_W'(col_pre) + OFFSET_W'(row_pre) * COLS_MUL;

  always_comb begin
    tab_sum = ({1'b0, col_pre} + TAB_STEP) & ~(COL_W+1)'(7);
    col_n   = col_pre;
    row_n   = row_pre;
    result.screen_clear = clr;
    result.write_valid  = 1'b0;
    result.write_cell   = '0;
    result.write_char   = '0;
    unique case (char_code)
      CH_RETURN: begin
        col_n = '0;
      end
      CH_NEWLINE: begin
        col_n = '0;
        row_n = row_pre + ROW_W'(1);
      end
      CH_BACKSPACE: begin
        if (col_pre != '0) col_n = col_pre - COL_W'(1);
      end
      CH_TAB: begin
        col_n = tab_sum[COL_W] ? COLUMN_MAX : tab_sum[COL_W-1:0];
      end
      default: begin
        result.write_valid = 1'b1;
        result.write_cell  = cell_full[CELL_W-1:0];
        result.write_char  = char_code;
        col_n = (col_pre == COLUMN_MAX) ? COLUMN_MAX : col_pre + COL_W'(1);
      end
    endcase
    result.cursor_pos  = OFFSET_W'(col_n) + OFFSET_W'(row_n) * COLS_MUL;
    cursor_next.column = col_n;
    cursor_next.row    = row_n;
  end

endmodule

FILE: rtl/tcce_out_reg.sv
// Result register that holds one result word until the consumer takes it.
module tcce_out_reg import tcce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    can_load,
  output logic    valid,
  input  logic    ready,
  output result_t data
);

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= load_data;
    end
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the text console cursor engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_PCT = 13;
  localparam int CALM_FIRST = 300;
  localparam int CALM_LAST = 900;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_ready;
  logic [CHAR_W-1:0] char_code = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic screen_clear;
  logic write_valid;
  logic [CELL_W-1:0] write_cell;
  logic [CHAR_W-1:0] write_char;
  logic [OFFSET_W-1:0] cursor_pos;

  logic [CHAR_W-1:0] pending_chars[$];
  result_t expected_results[$];
  logic [COL_W-1:0] cur_col = '0;
  logic [ROW_W-1:0] cur_row = '0;
  int mismatches = 0;
  int cycle_count = 0;

  text_console_cursor_engine dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_code(char_code),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .screen_clear(screen_clear),
    .write_valid(write_valid),
    .write_cell(write_cell),
    .write_char(write_char),
    .cursor_pos(cursor_pos)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic calm_window();
    return cycle_count >= CALM_FIRST && cycle_count < CALM_LAST;
  endfunction

  function automatic logic take_break();
    return !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Advances the cursor for one character and returns the word it produces.
  function automatic result_t advance_cursor(logic [CHAR_W-1:0] ch);
    result_t r;
    int c;
    int rw;
    int nxt;
    r = '0;
    c = cur_col;
    rw = cur_row;
    if (c > COLUMNS - 1) begin
      c = 0;
      rw = (rw + 1) & 'h1F;
    end
    if (rw > ROWS - 1) begin
      rw = 0;
      r.screen_clear = 1'b1;
    end
    case (ch)
      CH_RETURN: c = 0;
      CH_NEWLINE: begin
        c = 0;
        rw = (rw + 1) & 'h1F;
      end
      CH_BACKSPACE: if (c > 0) c = c - 1;
      CH_TAB: begin
        nxt = (c + 8) & ~7;
        c = (nxt > int'(COLUMN_MAX)) ? int'(COLUMN_MAX) : nxt;
      end
      default: begin
        r.write_valid = 1'b1;
        r.write_cell = CELL_W'(c + COLUMNS * rw);
        r.write_char = ch;
        c = c + 1;
        if (c > int'(COLUMN_MAX)) c = int'(COLUMN_MAX);
      end
    endcase
    r.cursor_pos = OFFSET_W'(c + rw * COLUMNS);
    cur_col = COL_W'(c);
    cur_row = ROW_W'(rw);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready)
        expected_results.push_back(advance_cursor(char_code));
      if (!char_valid || char_ready) begin
        if (pending_chars.size() != 0 && !take_break()) begin
          char_valid <= 1'b1;
          char_code <= pending_chars.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word, position", cursor_pos, 0);
        end else begin
          want = expected_results.pop_front();
          if (screen_clear !== want.screen_clear)
            report_mismatch("screen_clear", screen_clear, want.screen_clear);
          if (write_valid !== want.write_valid)
            report_mismatch("write_valid", write_valid, want.write_valid);
          if (write_cell !== want.write_cell)
            report_mismatch("write_cell", write_cell, want.write_cell);
          if (write_char !== want.write_char)
            report_mismatch("write_char", write_char, want.write_char);
          if (cursor_pos !== want.cursor_pos)
            report_mismatch("cursor_pos", cursor_pos, want.cursor_pos);
        end
      end
      result_ready <= !take_break();
    end
  end

  initial begin
    int pick;
    int run;
    // byte extremes, backspace stop at column 0, tabs past the last column, wrap
    pending_chars.push_back(8'h00);
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(8'h7F);
    pending_chars.push_back(8'h80);
    pending_chars.push_back(CH_BACKSPACE);
    pending_chars.push_back(CH_BACKSPACE);
    pending_chars.push_back(CH_BACKSPACE);
    pending_chars.push_back(CH_BACKSPACE);
    pending_chars.push_back(CH_BACKSPACE);
    pending_chars.push_back(8'h41);
    pending_chars.push_back(CH_RETURN);
    repeat (10) pending_chars.push_back(CH_TAB);
    pending_chars.push_back(8'h5A);
    pending_chars.push_back(CH_NEWLINE);
    pending_chars.push_back(CH_NEWLINE);
    pending_chars.push_back(8'h20);

    // lines of text with control bytes mixed in, plus random noise
    while (pending_chars.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 30);
        repeat (run) pending_chars.push_back(CHAR_W'($urandom_range(8'h20, 8'hFF)));
        case ($urandom_range(0, 3))
          0: pending_chars.push_back(CH_RETURN);
          1: pending_chars.push_back(CH_TAB);
          2: pending_chars.push_back(CH_BACKSPACE);
          default: pending_chars.push_back(CH_NEWLINE);
        endcase
        if ($urandom_range(0, 1) == 0) pending_chars.push_back(CH_NEWLINE);
      end else if (pick < 85) begin
        pending_chars.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) pending_chars.push_back(CH_NEWLINE);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0 || char_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
